@@ rtl/tmc_pkg.sv @@
// thermostat mode controller package: widths, register and mode codes, reset values
// and the fixed-point temperature conversions
// no dependencies
package tmc_pkg;

  localparam int ADC_BITS  = 10;
  localparam int ADC_W     = 10;
  localparam int ADC_FULL  = (1 << ADC_BITS) - 1;
  localparam int PROD_W    = ADC_BITS + 9;
  localparam int SP_W      = 7;
  localparam int MEAS_W    = 9;
  localparam int CFG_IDX_W = 2;

  typedef logic [SP_W-1:0]   setpoint_t;
  typedef logic [MEAS_W-1:0] measured_t;
  typedef logic [7:0]        celsius_t;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW_C  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH_C = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW_F  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH_F = 2'd3;

  localparam logic [1:0] MODE_FAN  = 2'd0;
  localparam logic [1:0] MODE_HEAT = 2'd1;
  localparam logic [1:0] MODE_COOL = 2'd2;
  localparam logic [1:0] MODE_AUTO = 2'd3;

  localparam setpoint_t LIMIT_LOW_C_RESET  = 7'd15;
  localparam setpoint_t LIMIT_HIGH_C_RESET = 7'd50;
  localparam setpoint_t LIMIT_LOW_F_RESET  = 7'd59;
  localparam setpoint_t LIMIT_HIGH_F_RESET = 7'd122;
  localparam setpoint_t SETPOINT_RESET     = 7'd20;

  // floor(adc * 330 / full) saturated to 255
  function automatic celsius_t scale_sample(input logic [ADC_BITS-1:0] adc);
    logic [PROD_W-1:0] x;
    logic [PROD_W-1:0] q0;
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] q;
    x  = PROD_W'(adc) * PROD_W'(330);
    q0 = (x >> ADC_BITS) + (x >> (2 * ADC_BITS));
    r  = x - q0 * PROD_W'(ADC_FULL);
    if (r >= PROD_W'(2 * ADC_FULL)) begin
      q = q0 + PROD_W'(2);
    end else if (r >= PROD_W'(ADC_FULL)) begin
      q = q0 + PROD_W'(1);
    end else begin
      q = q0;
    end
    return (q > PROD_W'(255)) ? 8'hff : q[7:0];
  endfunction

  // floor(c * 9 / 5) + 32
  function automatic measured_t to_fahr(input celsius_t c);
    logic [11:0] y;
    logic [21:0] p;
    y = 12'(c) * 12'd9;
    p = 22'(y) * 22'd1639;
    return p[21:13] + 9'd32;
  endfunction

  function automatic setpoint_t sp_to_f(input setpoint_t s);
    measured_t f;
    f = to_fahr({1'b0, s});
    return (f > 9'd127) ? 7'd127 : f[6:0];
  endfunction

  // (s - 32) * 5 / 9, zero below 32
  function automatic setpoint_t sp_to_c(input setpoint_t s);
    logic [6:0]  d;
    logic [8:0]  y;
    logic [15:0] p;
    d = s - 7'd32;
    y = 9'(d) * 9'd5;
    p = 16'(y) * 16'd114;
    return (s < 7'd32) ? 7'd0 : {1'b0, p[15:10]};
  endfunction

endpackage

@@ rtl/thermostat_mode_controller.sv @@
// thermostat mode controller top level: input stage, state update and result register
// depends on tmc_pkg
//
// Each beat on the input carries either an ADC sample (func 0) or a button tick
// (func 1) and produces exactly one result beat with the heater, cooler and fan
// drives and the controller status. The sample is scaled to Celsius in the input
// stage; the state update then applies it, or the tick's buttons in the order
// power, unit, mode, up, down, to the state and loads the result register. One
// item is taken every cycle while the result side keeps up. Setpoint limits are
// written through the configuration port, which is always ready; write it only
// while no item is in flight.
module thermostat_mode_controller
  import tmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [ADC_W-1:0]     adc_sample,
  input  logic                 press_power,
  input  logic                 press_unit,
  input  logic                 press_mode,
  input  logic                 press_up,
  input  logic                 press_down,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 heater_on,
  output logic                 cooler_on,
  output logic                 fan_on,
  output logic                 powered,
  output logic                 in_fahrenheit,
  output logic [1:0]           run_mode,
  output setpoint_t            setpoint_out,
  output measured_t            measured_out,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SP_W-1:0]      cfg_data
);

  setpoint_t limit_low_c, limit_high_c, limit_low_f, limit_high_f;

  logic      power_flag, unit_flag;
  logic [1:0] mode_reg;
  setpoint_t setpoint_reg;
  measured_t measured_reg;

  logic      s1_valid, s1_func, s1_power, s1_unit, s1_mode, s1_up, s1_down;
  celsius_t  s1_celsius;

  logic      out_take, advance, in_accept;

  logic      power_next, unit_next;
  logic [1:0] mode_next;
  setpoint_t setpoint_next, sp_up, hi_limit, lo_limit;
  measured_t measured_next;
  logic      above, below, heat_next, cool_next, fan_next;

  assign cfg_ready = 1'b1;
  assign out_take  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_take;
  assign in_stall  = s1_valid && !out_take;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_low_c  <= LIMIT_LOW_C_RESET;
      limit_high_c <= LIMIT_HIGH_C_RESET;
      limit_low_f  <= LIMIT_LOW_F_RESET;
      limit_high_f <= LIMIT_HIGH_F_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMIT_LOW_C:  limit_low_c  <= cfg_data;
        REG_LIMIT_HIGH_C: limit_high_c <= cfg_data;
        REG_LIMIT_LOW_F:  limit_low_f  <= cfg_data;
        REG_LIMIT_HIGH_F: limit_high_f <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func    <= func;
      s1_celsius <= scale_sample(ADC_BITS'(adc_sample));
      s1_power   <= press_power;
      s1_unit    <= press_unit;
      s1_mode    <= press_mode;
      s1_up      <= press_up;
      s1_down    <= press_down;
    end
  end

  always_comb begin
    power_next    = power_flag;
    unit_next     = unit_flag;
    mode_next     = mode_reg;
    setpoint_next = setpoint_reg;
    measured_next = measured_reg;
    hi_limit      = unit_flag ? limit_high_f : limit_high_c;
    lo_limit      = unit_flag ? limit_low_f : limit_low_c;
    sp_up         = setpoint_reg;
    if (!s1_func) begin
      measured_next = unit_flag ? to_fahr(s1_celsius) : {1'b0, s1_celsius};
    end else begin
      if (s1_power) begin
        power_next = !power_flag;
      end
      if (!power_next) begin
        unit_next     = 1'b0;
        mode_next     = MODE_FAN;
        setpoint_next = SETPOINT_RESET;
      end else begin
        if (s1_unit) begin
          unit_next     = !unit_flag;
          setpoint_next = unit_next ? sp_to_f(setpoint_reg) : sp_to_c(setpoint_reg);
        end
        if (s1_mode) begin
          mode_next = mode_reg + 2'd1;
        end
        hi_limit = unit_next ? limit_high_f : limit_high_c;
        lo_limit = unit_next ? limit_low_f : limit_low_c;
        sp_up    = (s1_up && setpoint_next < hi_limit) ? setpoint_next + 7'd1 : setpoint_next;
        setpoint_next = (s1_down && sp_up > lo_limit) ? sp_up - 7'd1 : sp_up;
      end
    end
  end

  always_comb begin
    above     = {2'b00, setpoint_next} > measured_next;
    below     = {2'b00, setpoint_next} < measured_next;
    heat_next = 1'b0;
    cool_next = 1'b0;
    fan_next  = 1'b0;
    if (power_next) begin
      case (mode_next)
        MODE_FAN: begin
          fan_next = 1'b1;
        end
        MODE_HEAT: begin
          heat_next = above;
          fan_next  = above;
        end
        MODE_COOL: begin
          cool_next = below;
          fan_next  = below;
        end
        default: begin
          heat_next = above;
          cool_next = below;
          fan_next  = above || below;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_flag   <= 1'b0;
      unit_flag    <= 1'b0;
      mode_reg     <= MODE_FAN;
      setpoint_reg <= SETPOINT_RESET;
      measured_reg <= '0;
    end else if (advance) begin
      power_flag   <= power_next;
      unit_flag    <= unit_next;
      mode_reg     <= mode_next;
      setpoint_reg <= setpoint_next;
      measured_reg <= measured_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      heater_on     <= heat_next;
      cooler_on     <= cool_next;
      fan_on        <= fan_next;
      powered       <= power_next;
      in_fahrenheit <= unit_next;
      run_mode      <= mode_next;
      setpoint_out  <= setpoint_next;
      measured_out  <= measured_next;
    end
  end

endmodule

@@ rtl/tmc_checker.sv @@
// port-level checks for the thermostat mode controller and their bind
// depends on tmc_pkg and thermostat_mode_controller
module tmc_checker
  import tmc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input logic      heater_on,
  input logic      cooler_on,
  input logic      fan_on,
  input logic      powered,
  input logic      in_fahrenheit,
  input logic [1:0] run_mode,
  input setpoint_t setpoint_out
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_off_drives: assert property (@(posedge clk) disable iff (rst)
    out_valid && !powered |-> !heater_on && !cooler_on && !fan_on)
    else $error("drive active while powered off");

  a_off_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !powered |-> !in_fahrenheit && run_mode == MODE_FAN &&
                              setpoint_out == SETPOINT_RESET)
    else $error("status not at defaults while powered off");

  a_heat_cool: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(heater_on && cooler_on))
    else $error("heater and cooler both on");

  a_fan_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && (heater_on || cooler_on) |-> fan_on)
    else $error("heater or cooler on without fan");

endmodule

bind thermostat_mode_controller tmc_checker u_tmc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .heater_on     (heater_on),
  .cooler_on     (cooler_on),
  .fan_on        (fan_on),
  .powered       (powered),
  .in_fahrenheit (in_fahrenheit),
  .run_mode      (run_mode),
  .setpoint_out  (setpoint_out)
);

@@ sim/tb.sv @@
// self-checking testbench for thermostat_mode_controller: random and directed sample and
// button beats, checked against an in-bench model of the controller state
// depends on tmc_pkg and rtl/thermostat_mode_controller.sv
module tb;
  import tmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             func;
    logic [ADC_W-1:0] adc;
    logic             power;
    logic             unit;
    logic             mode;
    logic             up;
    logic             down;
  } event_t;

  typedef struct packed {
    logic       heater;
    logic       cooler;
    logic       fan;
    logic       pwr_on;
    logic       fahr;
    logic [1:0] run_mode;
    setpoint_t  setpoint;
    measured_t  measured;
  } status_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 func = 1'b0;
  logic [ADC_W-1:0]     adc_sample = '0;
  logic                 press_power = 1'b0;
  logic                 press_unit = 1'b0;
  logic                 press_mode = 1'b0;
  logic                 press_up = 1'b0;
  logic                 press_down = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 heater_on;
  logic                 cooler_on;
  logic                 fan_on;
  logic                 powered;
  logic                 in_fahrenheit;
  logic [1:0]           run_mode;
  setpoint_t            setpoint_out;
  measured_t            measured_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SP_W-1:0]      cfg_data = '0;

  thermostat_mode_controller u_top (.*);

  always #6 clk = ~clk;

  // controller model state
  logic       on_now = 1'b0;
  logic       fahr_now = 1'b0;
  logic [1:0] mode_now = MODE_FAN;
  setpoint_t  sp_now = SETPOINT_RESET;
  measured_t  meas_now = '0;
  setpoint_t  lim [4];

  event_t  pending_events [$];
  status_t expected_status [$];
  event_t  cur_event;
  int      sent_events = 0;
  int      taken_events = 0;
  int      fails = 0;
  bit      idle_en = 1'b1;
  bit      gen_on = 1'b0;
  int      hold_req_n = 0;
  int      hold_seen_n = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  function automatic status_t step_thermostat(input event_t ev);
    status_t r;
    int c;
    int sp;
    int hi;
    int lo;
    bit above;
    bit below;
    r = '0;
    if (!ev.func) begin
      c = ((int'(ev.adc) & ADC_FULL) * 330) / ADC_FULL;
      if (c > 255) c = 255;
      meas_now = fahr_now ? measured_t'(c * 9 / 5 + 32) : measured_t'(c);
    end else begin
      if (ev.power) on_now = !on_now;
      if (!on_now) begin
        fahr_now = 1'b0;
        mode_now = MODE_FAN;
        sp_now = SETPOINT_RESET;
      end else begin
        sp = int'(sp_now);
        if (ev.unit) begin
          fahr_now = !fahr_now;
          if (fahr_now) sp = (sp * 9 / 5 + 32 > 127) ? 127 : sp * 9 / 5 + 32;
          else sp = (sp >= 32) ? (sp - 32) * 5 / 9 : 0;
        end
        if (ev.mode) mode_now = mode_now + 2'd1;
        hi = fahr_now ? int'(lim[REG_LIMIT_HIGH_F]) : int'(lim[REG_LIMIT_HIGH_C]);
        lo = fahr_now ? int'(lim[REG_LIMIT_LOW_F]) : int'(lim[REG_LIMIT_LOW_C]);
        if (ev.up && sp < hi) sp++;
        if (ev.down && sp > lo) sp--;
        sp_now = setpoint_t'(sp);
      end
    end
    above = int'(sp_now) > int'(meas_now);
    below = int'(sp_now) < int'(meas_now);
    if (on_now) begin
      case (mode_now)
        MODE_FAN: begin
          r.fan = 1'b1;
        end
        MODE_HEAT: begin
          r.heater = above;
          r.fan = above;
        end
        MODE_COOL: begin
          r.cooler = below;
          r.fan = below;
        end
        default: begin
          r.heater = above;
          r.cooler = below;
          r.fan = above || below;
        end
      endcase
    end
    r.pwr_on = on_now;
    r.fahr = fahr_now;
    r.run_mode = mode_now;
    r.setpoint = sp_now;
    r.measured = meas_now;
    return r;
  endfunction

  function automatic event_t sample_evt(input int adc);
    event_t ev;
    ev = '0;
    ev.adc = ADC_W'(adc);
    return ev;
  endfunction

  function automatic event_t tick_evt(input bit pw, input bit un, input bit md,
                                      input bit up, input bit dn);
    event_t ev;
    ev = '0;
    ev.func = 1'b1;
    ev.adc = ADC_W'($urandom);
    ev.power = pw;
    ev.unit = un;
    ev.mode = md;
    ev.up = up;
    ev.down = dn;
    if (pw) gen_on = !gen_on;
    return ev;
  endfunction

  // samples and mostly powered-on ticks with a per-burst up/down bias so the limits get reached
  function automatic event_t random_event(input int up_pct);
    event_t ev;
    if ($urandom_range(99) < 50) begin
      ev = sample_evt(($urandom_range(1) == 1) ? $urandom_range(0, 420)
                                               : $urandom_range(0, 1023));
      ev.power = 1'($urandom);
      ev.unit = 1'($urandom);
      ev.mode = 1'($urandom);
      ev.up = 1'($urandom);
      ev.down = 1'($urandom);
    end else begin
      ev = tick_evt(gen_on ? ($urandom_range(99) < 3) : ($urandom_range(99) < 70),
                    $urandom_range(99) < 12, $urandom_range(99) < 25,
                    $urandom_range(99) < up_pct, $urandom_range(99) < 100 - up_pct);
    end
    return ev;
  endfunction

  task automatic check_field(input string nm, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d got %0d", $time, nm, want, got);
      fails++;
    end
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input setpoint_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    lim[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_limits(input setpoint_t lc, input setpoint_t hc,
                              input setpoint_t lf, input setpoint_t hf);
    write_limit(REG_LIMIT_LOW_C, lc);
    write_limit(REG_LIMIT_HIGH_C, hc);
    write_limit(REG_LIMIT_LOW_F, lf);
    write_limit(REG_LIMIT_HIGH_F, hf);
  endtask

  task automatic wait_drained();
    while (!(pending_events.size() == 0 && taken_events == sent_events &&
             expected_status.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input bit idle, input bit hold);
    int up_pct;
    up_pct = 50;
    idle_en = idle;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) up_pct = $urandom_range(10, 90);
      pending_events.push_back(random_event(up_pct));
    end
    if (hold) hold_req_n++;
    wait_drained();
  endtask

  // input driver
  always @(negedge clk) begin
    if (!in_valid || taken_events == sent_events) begin
      if (!rst && pending_events.size() > 0 && !(idle_en && $urandom_range(99) < 27)) begin
        cur_event = pending_events.pop_front();
        func <= cur_event.func;
        adc_sample <= cur_event.adc;
        press_power <= cur_event.power;
        press_unit <= cur_event.unit;
        press_mode <= cur_event.mode;
        press_up <= cur_event.up;
        press_down <= cur_event.down;
        in_valid <= 1'b1;
        sent_events++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted input beat: run the model
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_status.push_back(step_thermostat(cur_event));
      taken_events++;
    end
  end

  // result side stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left == 0 && hold_seen_n != hold_req_n) begin
      hold_seen_n = hold_req_n;
      hold_left = 200;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 27);
    end
  end

  // result monitor
  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $display("%0t ns: result beat with nothing expected", $time);
        fails++;
      end else begin
        want = expected_status.pop_front();
        check_field("heater_on", want.heater, heater_on);
        check_field("cooler_on", want.cooler, cooler_on);
        check_field("fan_on", want.fan, fan_on);
        check_field("powered", want.pwr_on, powered);
        check_field("in_fahrenheit", want.fahr, in_fahrenheit);
        check_field("run_mode", want.run_mode, run_mode);
        check_field("setpoint_out", want.setpoint, setpoint_out);
        check_field("measured_out", want.measured, measured_out);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 2000) begin
      $display("%0t ns: no progress", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    lim[REG_LIMIT_LOW_C] = LIMIT_LOW_C_RESET;
    lim[REG_LIMIT_HIGH_C] = LIMIT_HIGH_C_RESET;
    lim[REG_LIMIT_LOW_F] = LIMIT_LOW_F_RESET;
    lim[REG_LIMIT_HIGH_F] = LIMIT_HIGH_F_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: adc extremes, buttons while off, every mode, unit round trip
    pending_events.push_back(sample_evt(0));
    pending_events.push_back(sample_evt(1023));
    pending_events.push_back(tick_evt(0, 1, 1, 1, 1));
    pending_events.push_back(tick_evt(1, 0, 0, 0, 0));
    pending_events.push_back(tick_evt(0, 0, 0, 1, 0));
    pending_events.push_back(tick_evt(0, 0, 0, 0, 1));
    pending_events.push_back(tick_evt(0, 0, 1, 0, 0));
    pending_events.push_back(sample_evt(100));
    pending_events.push_back(sample_evt(31));
    pending_events.push_back(tick_evt(0, 0, 1, 0, 0));
    pending_events.push_back(sample_evt(50));
    pending_events.push_back(tick_evt(0, 0, 1, 0, 0));
    pending_events.push_back(sample_evt(62));
    pending_events.push_back(sample_evt(1023));
    pending_events.push_back(tick_evt(0, 1, 0, 0, 0));
    pending_events.push_back(sample_evt(1023));
    pending_events.push_back(sample_evt(512));
    pending_events.push_back(tick_evt(0, 1, 1, 1, 1));
    pending_events.push_back(tick_evt(1, 0, 0, 0, 0));
    pending_events.push_back(tick_evt(0, 0, 0, 1, 0));
    pending_events.push_back(tick_evt(1, 1, 1, 1, 1));
    pending_events.push_back(tick_evt(1, 0, 0, 0, 0));
    wait_drained();

    write_limits(7'd0, 7'd127, 7'd0, 7'd127);
    run_phase(190, 1'b1, 1'b0);
    // limits out of order
    write_limits(7'd70, 7'd10, 7'd127, 7'd0);
    run_phase(190, 1'b1, 1'b0);
    write_limits(setpoint_t'($urandom), setpoint_t'($urandom),
                 setpoint_t'($urandom), setpoint_t'($urandom));
    run_phase(190, 1'b1, 1'b0);
    write_limits(LIMIT_LOW_C_RESET, LIMIT_HIGH_C_RESET,
                 LIMIT_LOW_F_RESET, LIMIT_HIGH_F_RESET);
    run_phase(190, 1'b0, 1'b1);
    write_limits(setpoint_t'($urandom_range(0, 40)), setpoint_t'($urandom_range(20, 127)),
                 setpoint_t'($urandom_range(0, 80)), setpoint_t'($urandom_range(60, 127)));
    run_phase(190, 1'b1, 1'b0);

    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
